// File: rtl/cba_pkg.sv
package cba_pkg;

   localparam int NUM_BLOCKS = 1024;

   // widths of the transaction fields
   localparam int IDX_W    = 10;
   localparam int CNT_W    = IDX_W + 1;
   localparam int LEN_W    = 24;
   localparam int BSL_W    = 5;
   localparam int STATUS_W = 2;
   localparam int SUM_W    = LEN_W + 1;

   localparam logic [BSL_W-1:0] BSL_RESET = 5'd10;
   localparam logic [BSL_W-1:0] BSL_MAX   = 5'd16;

   localparam logic [CNT_W-1:0] NUM_BLOCKS_C = CNT_W'(NUM_BLOCKS);

   // free map storage: one word holds the free bits of WORD_W blocks
   localparam int WORD_W  = 8;
   localparam int WORDS   = NUM_BLOCKS / WORD_W;
   localparam int WADDR_W = $clog2(WORDS);
   localparam int BIT_W   = $clog2(WORD_W);
   localparam int PTR_W   = WADDR_W + 1;
   localparam int POP_W   = BIT_W + 1;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_PAD_W   = RSP_TDATA_W - (3 * CNT_W + STATUS_W);

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BEYOND   = 2'd2;

   typedef enum logic [2:0] {
      RES_ALLOC_OK,
      RES_ALLOC_ZERO,
      RES_NO_SPACE,
      RES_BEYOND,
      RES_FREE_OK
   } res_code_type;

   typedef enum logic [1:0] {
      SRC_HW,
      SRC_SCAN,
      SRC_FREE
   } range_src_type;

   typedef struct packed {
      logic          load;
      logic          calc;
      logic          scan_init;
      logic          scan_step;
      logic          range_load;
      range_src_type range_src;
      logic          mark_step;
      logic          result_load;
      res_code_type  result_code;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic cnt_zero;
      logic cnt_fits;
      logic app_ok;
      logic free_beyond;
      logic scan_found;
      logic scan_miss;
      logic mark_done;
   } stat_type;

   typedef struct packed {
      logic [CNT_W-1:0]    used_extent;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    run_blocks;
      logic [CNT_W-1:0]    start_index;
   } result_type;

endpackage

// File: rtl/contiguous_block_allocator_core.sv
// First-fit allocator of contiguous block runs over a 1024-entry free map.
// req channel: one transaction per allocate or free request; tuser is the op
//   (0 allocate, 1 free). rsp channel: exactly one transaction per request,
//   in request order, carrying start index, run length, status, used extent.
// csr port: csr_wr_en writes block_size_log2 (block size 2^n bytes, n>16
//   acts as 16); write only while no request is in flight.
// Path from req acceptance to rsp_tvalid:
//   free with zero count, free beyond the mark, zero-length allocate and
//   out-of-space without a scan: no free map access
//   allocate or free that updates the map: also walks the free map words
//   (8 blocks each) touched by the run
//   allocate that scans first: scans words before that, up to ceil(mark / 8)
// The free map is one 8-bit-wide memory, one read and one write a cycle;
// scan and update each walk it a word per cycle, so one request runs at a time.
// req_tready returns in the cycle after a result is loaded, not before.
// A result waits in an output register; req_tready returns with the next
// request's turn even while rsp_tvalid is held by a stalled receiver, but a
// second result waits until the first is taken.
// Reset clears the high-water mark and free count and sets the block size
// to 1 KiB; map words at or above the mark read as used, so no clearing pass.
module contiguous_block_allocator_core import cba_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [BSL_W-1:0]       csr_wr_data,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [23:0] byte_length, [33:24] free_start, [44:34] free_count, [47:45] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] op
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [10:0] start_index, [21:11] run_blocks, [23:22] status,
   // [34:24] used_extent, [39:35] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   cmd_type    cmd;
   stat_type   stat;
   result_type result;
   logic       out_free;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_res_ff, rsp_res_in;

   assign out_free = !rsp_valid_ff || rsp_tready;

   cba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .out_free (out_free),
      .stat     (stat),
      .in_ready (req_tready),
      .cmd      (cmd)
   );

   cba_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .in_op          (req_tuser),
      .in_byte_length (req_tdata[LEN_W-1:0]),
      .in_free_start  (req_tdata[LEN_W +: IDX_W]),
      .in_free_count  (req_tdata[LEN_W+IDX_W +: CNT_W]),
      .cmd            (cmd),
      .stat           (stat),
      .result         (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_res_ff.used_extent, rsp_res_ff.status,
                        rsp_res_ff.run_blocks, rsp_res_ff.start_index};

`ifndef NO_ASSERTIONS
   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> out_free)
      else $error("result loaded over an untaken transaction");

   a_single_request: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while one is in flight");

   a_extent_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_res_ff.used_extent <= NUM_BLOCKS_C))
      else $error("used extent beyond the store");

   a_no_space_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_res_ff.status != ST_OK)) |->
         ((rsp_res_ff.run_blocks == '0) && (rsp_res_ff.start_index == '0)))
      else $error("failed request returned a run");
`endif

endmodule

// File: rtl/cba_ctrl.sv
module cba_ctrl import cba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  logic     out_free,
   input  stat_type stat,
   output logic     in_ready,
   output cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CALC   = 6'b000010,
      S_DECIDE = 6'b000100,
      S_SCAN   = 6'b001000,
      S_MARK   = 6'b010000,
      S_RESULT = 6'b100000
   } state_type;

   state_type    state_ff, state_in;
   res_code_type res_code_ff, res_code_in;

   always_comb begin
      state_in        = state_ff;
      res_code_in     = res_code_ff;
      cmd             = '0;
      cmd.result_code = res_code_ff;
      in_ready        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (stat.is_free) begin
               if (stat.cnt_zero) begin
                  res_code_in = RES_FREE_OK;
                  state_in    = S_RESULT;
               end else if (stat.free_beyond) begin
                  res_code_in = RES_BEYOND;
                  state_in    = S_RESULT;
               end else begin
                  cmd.range_load = 1'b1;
                  cmd.range_src  = SRC_FREE;
                  res_code_in    = RES_FREE_OK;
                  state_in       = S_MARK;
               end
            end else if (stat.cnt_zero) begin
               res_code_in = RES_ALLOC_ZERO;
               state_in    = S_RESULT;
            end else if (stat.cnt_fits) begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end else if (stat.app_ok) begin
               cmd.range_load = 1'b1;
               cmd.range_src  = SRC_HW;
               res_code_in    = RES_ALLOC_OK;
               state_in       = S_MARK;
            end else begin
               res_code_in = RES_NO_SPACE;
               state_in    = S_RESULT;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_found) begin
               cmd.range_load = 1'b1;
               cmd.range_src  = SRC_SCAN;
               res_code_in    = RES_ALLOC_OK;
               state_in       = S_MARK;
            end else if (stat.scan_miss) begin
               // no free run below the mark: append instead
               if (stat.app_ok) begin
                  cmd.range_load = 1'b1;
                  cmd.range_src  = SRC_HW;
                  res_code_in    = RES_ALLOC_OK;
                  state_in       = S_MARK;
               end else begin
                  res_code_in = RES_NO_SPACE;
                  state_in    = S_RESULT;
               end
            end
         end
         S_MARK: begin
            cmd.mark_step = 1'b1;
            if (stat.mark_done) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         res_code_ff <= RES_FREE_OK;
      end else begin
         state_ff    <= state_in;
         res_code_ff <= res_code_in;
      end
   end

endmodule

// File: rtl/cba_datapath.sv
module cba_datapath import cba_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [BSL_W-1:0] csr_wr_data,
   input  logic             in_op,
   input  logic [LEN_W-1:0] in_byte_length,
   input  logic [IDX_W-1:0] in_free_start,
   input  logic [CNT_W-1:0] in_free_count,
   input  cmd_type          cmd,
   output stat_type         stat,
   output result_type       result
);

   function automatic logic [POP_W-1:0] popcount(input logic [WORD_W-1:0] v);
      logic [POP_W-1:0] n;
      n = '0;
      for (int j = 0; j < WORD_W; j++) begin
         n = n + POP_W'(v[j]);
      end
      return n;
   endfunction

   logic [BSL_W-1:0]   bsl_ff, bsl_in;
   logic               op_ff, op_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [IDX_W-1:0]   fstart_ff, fstart_in;
   logic [CNT_W-1:0]   fcount_ff, fcount_in;
   logic [LEN_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   hw_ff, hw_in;
   logic [CNT_W-1:0]   ft_ff, ft_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [WADDR_W-1:0] pw_ff, pw_in;
   logic [CNT_W-1:0]   run_ff, run_in;
   logic               found_ff, found_in;
   logic [CNT_W-1:0]   fend_ff, fend_in;
   logic [WORD_W-1:0]  rdata_ff;

   logic [WORD_W-1:0]  mem [WORDS];

   logic [BSL_W-1:0]   bsl_clamp;
   logic [SUM_W-1:0]   round_add;
   logic [SUM_W-1:0]   len_sum;
   logic [LEN_W-1:0]   alloc_cnt;
   logic [CNT_W-1:0]   cnt_short;
   logic [CNT_W-1:0]   base_idx;
   logic [WORD_W-1:0]  vmask, rmask, mword;
   logic [CNT_W-1:0]   run_c;
   logic               hit_c;
   logic [CNT_W-1:0]   fend_c;
   logic [CNT_W-1:0]   lo_c, hi_c;
   logic [CNT_W-1:0]   hw_m1, hi_m1;
   logic [WADDR_W-1:0] last_scan, last_mark;
   logic               scan_proc, mark_proc;
   logic               scan_issue, mark_issue;
   logic               mem_we;
   logic [WORD_W-1:0]  mem_wdata;
   logic [CNT_W-1:0]   extent_c;
   logic [CNT_W:0]     free_end;

   // block count: byte length rounded up to whole blocks
   always_comb begin
      bsl_clamp = (bsl_ff > BSL_MAX) ? BSL_MAX : bsl_ff;
      round_add = (SUM_W'(1) << bsl_clamp) - SUM_W'(1);
      len_sum   = SUM_W'(len_ff) + round_add;
      alloc_cnt = LEN_W'(len_sum >> bsl_clamp);
   end

   assign cnt_short = count_ff[CNT_W-1:0];
   assign base_idx  = {1'b0, pw_ff, {BIT_W{1'b0}}};

   // bits at or above the high-water mark are masked and read as used
   always_comb begin
      for (int j = 0; j < WORD_W; j++) begin
         vmask[j] = (base_idx | CNT_W'(j)) < hw_ff;
         rmask[j] = ((base_idx | CNT_W'(j)) >= lo_ff) && ((base_idx | CNT_W'(j)) < hi_ff);
      end
      mword = rdata_ff & vmask;
   end

   // run of free bits carried across words, first hit wins
   always_comb begin
      run_c  = run_ff;
      hit_c  = 1'b0;
      fend_c = '0;
      for (int j = 0; j < WORD_W; j++) begin
         if (!hit_c) begin
            run_c = mword[j] ? run_c + CNT_W'(1) : '0;
            if (run_c == cnt_short) begin
               hit_c  = 1'b1;
               fend_c = (base_idx | CNT_W'(j)) + CNT_W'(1);
            end
         end
      end
   end

   always_comb begin
      unique case (cmd.range_src)
         SRC_HW: begin
            lo_c = hw_ff;
            hi_c = hw_ff + cnt_short;
         end
         SRC_SCAN: begin
            lo_c = fend_ff - cnt_short;
            hi_c = fend_ff;
         end
         SRC_FREE: begin
            lo_c = {1'b0, fstart_ff};
            hi_c = {1'b0, fstart_ff} + fcount_ff;
         end
         default: begin
            lo_c = hw_ff;
            hi_c = hw_ff;
         end
      endcase
   end

   assign hw_m1     = hw_ff - CNT_W'(1);
   assign hi_m1     = hi_ff - CNT_W'(1);
   assign last_scan = hw_m1[IDX_W-1:BIT_W];
   assign last_mark = hi_m1[IDX_W-1:BIT_W];

   assign scan_issue = cmd.scan_step && !found_ff && (rptr_ff <= {1'b0, last_scan});
   assign mark_issue = cmd.mark_step && (rptr_ff <= {1'b0, last_mark});
   assign scan_proc  = cmd.scan_step && rd_valid_ff && !found_ff;
   assign mark_proc  = cmd.mark_step && rd_valid_ff;

   assign mem_we    = mark_proc;
   assign mem_wdata = (op_ff == OP_FREE) ? (mword | rmask) : (mword & ~rmask);

   assign extent_c = (hi_ff > hw_ff) ? hi_ff : hw_ff;
   assign free_end = (CNT_W+1)'(fstart_ff) + (CNT_W+1)'(fcount_ff);

   always_comb begin
      bsl_in      = csr_wr_en ? csr_wr_data : bsl_ff;
      op_in       = op_ff;
      len_in      = len_ff;
      fstart_in   = fstart_ff;
      fcount_in   = fcount_ff;
      count_in    = count_ff;
      hw_in       = hw_ff;
      ft_in       = ft_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      rptr_in     = rptr_ff;
      rd_valid_in = 1'b0;
      pw_in       = pw_ff;
      run_in      = run_ff;
      found_in    = found_ff;
      fend_in     = fend_ff;

      if (cmd.load) begin
         op_in     = in_op;
         len_in    = in_byte_length;
         fstart_in = in_free_start;
         fcount_in = in_free_count;
      end
      if (cmd.calc) begin
         count_in = (op_ff == OP_FREE) ? LEN_W'(fcount_ff) : alloc_cnt;
      end

      if (cmd.scan_init) begin
         rptr_in  = '0;
         run_in   = '0;
         found_in = 1'b0;
      end else if (cmd.range_load) begin
         lo_in   = lo_c;
         hi_in   = hi_c;
         rptr_in = PTR_W'(lo_c[IDX_W-1:BIT_W]);
      end else if (scan_issue || mark_issue) begin
         rd_valid_in = 1'b1;
         pw_in       = rptr_ff[WADDR_W-1:0];
         rptr_in     = rptr_ff + PTR_W'(1);
      end

      if (scan_proc) begin
         run_in = run_c;
         if (hit_c) begin
            found_in = 1'b1;
            fend_in  = fend_c;
         end
      end

      if (mark_proc) begin
         if (op_ff == OP_FREE) begin
            ft_in = ft_ff + CNT_W'(popcount(~mword & rmask));
         end else begin
            ft_in = ft_ff - CNT_W'(popcount(mword & rmask));
         end
      end

      if (cmd.result_load && (cmd.result_code == RES_ALLOC_OK)) begin
         hw_in = extent_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsl_ff      <= BSL_RESET;
         hw_ff       <= '0;
         ft_ff       <= '0;
         rd_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         bsl_ff      <= bsl_in;
         hw_ff       <= hw_in;
         ft_ff       <= ft_in;
         rd_valid_ff <= rd_valid_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      len_ff    <= len_in;
      fstart_ff <= fstart_in;
      fcount_ff <= fcount_in;
      count_ff  <= count_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      rptr_ff   <= rptr_in;
      pw_ff     <= pw_in;
      run_ff    <= run_in;
      fend_ff   <= fend_in;
   end

   // free map memory, one write and one read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[pw_ff] <= mem_wdata;
      end
      rdata_ff <= mem[rptr_ff[WADDR_W-1:0]];
   end

   always_comb begin
      stat.is_free     = (op_ff == OP_FREE);
      stat.cnt_zero    = (count_ff == '0);
      stat.cnt_fits    = (count_ff <= LEN_W'(ft_ff));
      stat.app_ok      = (count_ff <= LEN_W'(NUM_BLOCKS_C - hw_ff));
      stat.free_beyond = (free_end > (CNT_W+1)'(hw_ff));
      stat.scan_found  = found_ff;
      stat.scan_miss   = !found_ff && !rd_valid_ff && (rptr_ff > {1'b0, last_scan});
      stat.mark_done   = !rd_valid_ff && (rptr_ff > {1'b0, last_mark});
   end

   always_comb begin
      unique case (cmd.result_code)
         RES_ALLOC_OK: begin
            result.start_index = lo_ff;
            result.run_blocks  = cnt_short;
            result.status      = ST_OK;
            result.used_extent = extent_c;
         end
         RES_ALLOC_ZERO: begin
            result.start_index = hw_ff;
            result.run_blocks  = '0;
            result.status      = ST_OK;
            result.used_extent = hw_ff;
         end
         RES_NO_SPACE: begin
            result.start_index = '0;
            result.run_blocks  = '0;
            result.status      = ST_NO_SPACE;
            result.used_extent = hw_ff;
         end
         RES_BEYOND: begin
            result.start_index = '0;
            result.run_blocks  = '0;
            result.status      = ST_BEYOND;
            result.used_extent = hw_ff;
         end
         default: begin
            result.start_index = '0;
            result.run_blocks  = '0;
            result.status      = ST_OK;
            result.used_extent = hw_ff;
         end
      endcase
   end

endmodule
